/* rtl/kth_rank_stream_selector_defines.svh */
`ifndef KTH_RANK_STREAM_SELECTOR_DEFINES_SVH
`define KTH_RANK_STREAM_SELECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define KRS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define KRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/krs_pkg.sv */
package krs_pkg;

  localparam int DATA_W          = 32;
  localparam int RANK_W          = 5;
  localparam int STORE_DEPTH_DEF = 16;

  typedef enum logic [0:0] {
    REG_RANK_K       = 1'b0,
    REG_PICK_LARGEST = 1'b1
  } krs_reg_t;

  typedef struct packed {
    logic write_en;
    logic below_start;
    logic at_start;
    logic chain_head;
  } krs_cell_ctl_t;

endpackage

/* rtl/krs_cell.sv */
module krs_cell import krs_pkg::*; (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic                     pick_largest,
  input  krs_cell_ctl_t            ctl,
  input  logic signed [DATA_W-1:0] prev_value,
  input  logic                     prev_shift,
  input  logic                     next_shift,
  output logic signed [DATA_W-1:0] value,
  output logic                     better,
  output logic                     shift
);

  always_comb begin
    better = pick_largest ? (sample_value > value) : (sample_value < value);
    shift  = ctl.below_start & better & (ctl.chain_head | next_shift);
  end

  // entry moves down one place; the cell takes its upper neighbor or the new value
  always_ff @(posedge clk) begin
    if (ctl.write_en && (ctl.at_start || shift)) begin
      value <= prev_shift ? prev_value : sample_value;
    end
  end

endmodule

/* rtl/kth_rank_stream_selector.sv */
// The set_end beat sets rpt_pend; the result registers once the output is free.
// Throughput: one value per cycle while in_stall is low; every held entry compares
//   against it in parallel; the shift runs through the row of cells in that cycle.
// in_stall is raised only while a finished result waits behind a stalled output.
// Reset: held count cleared, rank_k = 3, pick_largest = 1; the stored entries keep
//   their contents and are only read after they have been written.
module kth_rank_stream_selector import krs_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [0:0]               wr_index,
  input  logic [RANK_W-1:0]        wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic                     set_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] ranked_value,
  output logic                     set_complete
);

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [RANK_W-1:0] rank_k;
  logic              pick_largest;
  logic [CW-1:0]     held_count;
  logic [CW-1:0]     held_count_next;
  logic              rpt_pend;
  logic [IW-1:0]     rpt_idx;
  logic              rpt_complete;

  logic [CW-1:0] kc;
  logic [CW-1:0] n;
  logic [CW-1:0] n_minus1;
  logic [CW-1:0] start;
  logic [CW-1:0] held_post;
  logic [CW-1:0] rn;
  logic [CW-1:0] rn_minus1;
  logic          full;
  logic          accept;
  logic          in_take;
  logic          rpt_move;

  logic signed [DATA_W-1:0] cell_value [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]   better_vec;
  logic [STORE_DEPTH-1:0]   shift_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k       <= RANK_W'(3);
      pick_largest <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        REG_RANK_K:       rank_k       <= wr_data;
        REG_PICK_LARGEST: pick_largest <= wr_data[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    if (rank_k == '0) begin
      kc = CW'(1);
    end else if (int'(rank_k) > STORE_DEPTH) begin
      kc = CW'(STORE_DEPTH);
    end else begin
      kc = CW'(rank_k);
    end
    n        = (held_count < kc) ? held_count : kc;
    n_minus1 = n - CW'(1);
    full     = (n == kc);
    start    = full ? n_minus1 : n;
    accept   = !full || better_vec[n_minus1[IW-1:0]];
    if (accept) begin
      held_post = full ? n : n + CW'(1);
    end else begin
      held_post = held_count;
    end
    rn        = (held_post < kc) ? held_post : kc;
    rn_minus1 = rn - CW'(1);
  end

  assign rpt_move = rpt_pend && (!out_valid || !out_stall);
  assign in_stall = rpt_pend && !rpt_move;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    held_count_next = held_count;
    if (in_take) begin
      held_count_next = set_end ? '0 : held_post;
    end
  end

  for (genvar j = 0; j < STORE_DEPTH; j++) begin : g_cell
    krs_cell_ctl_t            ctl;
    logic signed [DATA_W-1:0] prev_value;
    logic                     prev_shift;
    logic                     next_shift;

    always_comb begin
      ctl.write_en    = in_take && accept;
      ctl.below_start = CW'(j) < start;
      ctl.at_start    = CW'(j) == start;
      ctl.chain_head  = CW'(j + 1) == start;
    end

    if (j == 0) begin : g_first
      assign prev_value = sample_value;
      assign prev_shift = 1'b0;
    end else begin : g_inner
      assign prev_value = cell_value[j-1];
      assign prev_shift = shift_vec[j-1];
    end

    if (j == STORE_DEPTH - 1) begin : g_last
      assign next_shift = 1'b0;
    end else begin : g_link
      assign next_shift = shift_vec[j+1];
    end

    krs_cell u_cell (
      .clk          (clk),
      .sample_value (sample_value),
      .pick_largest (pick_largest),
      .ctl          (ctl),
      .prev_value   (prev_value),
      .prev_shift   (prev_shift),
      .next_shift   (next_shift),
      .value        (cell_value[j]),
      .better       (better_vec[j]),
      .shift        (shift_vec[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      rpt_pend   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      held_count <= held_count_next;
      if (in_take && set_end) begin
        rpt_pend <= 1'b1;
      end else if (rpt_move) begin
        rpt_pend <= 1'b0;
      end
      if (rpt_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && set_end) begin
      rpt_idx      <= rn_minus1[IW-1:0];
      rpt_complete <= (held_post >= kc);
    end
    if (rpt_move) begin
      ranked_value <= cell_value[rpt_idx];
      set_complete <= rpt_complete;
    end
  end

endmodule

/* rtl/krs_checker.sv */
`include "kth_rank_stream_selector_defines.svh"

module krs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic set_end,
  input logic out_valid,
  input logic out_stall
);

  logic last_take;

  assign last_take = in_valid && !in_stall && set_end;

  // input is held back only by a result stuck behind the output
  `KRS_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)

  // last beat, then a free output next cycle, gives a result
  `KRS_ASSERT_NEXT(a_result_due, last_take ##1 (!out_valid || !out_stall), out_valid)

  // a fresh result always follows a last beat via rpt_pend
  `KRS_ASSERT_SAME(a_no_spurious, $rose(out_valid), $past(last_take, 2))

  `KRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind kth_rank_stream_selector krs_checker u_krs_checker (.*);

/* bench/kth_rank_stream_selector_test.sv */
module kth_rank_stream_selector_test;
  import krs_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } sample_beat_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     complete;
  } rank_result_t;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CALM_AFTER   = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [0:0] wr_index = REG_RANK_K;
  logic [RANK_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DATA_W-1:0] sample_value = '0;
  logic set_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] ranked_value;
  logic set_complete;

  kth_rank_stream_selector dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_value(sample_value),
    .set_end(set_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ranked_value(ranked_value),
    .set_complete(set_complete)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [RANK_W-1:0] cfg_rank = 5'd3;
  logic cfg_largest = 1'b1;
  logic signed [DATA_W-1:0] top_ranks [STORE_DEPTH_DEF];
  int held_ranks = 0;

  sample_beat_t samples_to_send[$];
  rank_result_t expected_ranks[$];
  int items_queued = 0;
  int beats_accepted = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  logic beat_taken = 1'b0;
  logic idling = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  sample_beat_t next_beat;
  rank_result_t want;

  function automatic logic outranks(logic signed [DATA_W-1:0] a,
                                    logic signed [DATA_W-1:0] b);
    return cfg_largest ? (a > b) : (a < b);
  endfunction

  task automatic rank_sample(input logic signed [DATA_W-1:0] v, input logic last);
    int kc;
    int n;
    int pos;
    logic keep;
    rank_result_t res;
    kc = (cfg_rank == '0) ? 1 : int'(cfg_rank);
    if (kc > STORE_DEPTH_DEF)
      kc = STORE_DEPTH_DEF;
    n = (held_ranks < kc) ? held_ranks : kc;
    keep = 1'b1;
    pos = n;
    if (n < kc) begin
      n++;
    end else if (!outranks(v, top_ranks[n-1])) begin
      keep = 1'b0;
    end else begin
      pos = n - 1;
    end
    if (keep) begin
      while (pos > 0 && outranks(v, top_ranks[pos-1])) begin
        top_ranks[pos] = top_ranks[pos-1];
        pos--;
      end
      top_ranks[pos] = v;
      held_ranks = n;
    end
    if (last) begin
      n = (held_ranks < kc) ? held_ranks : kc;
      if (n >= kc) begin
        res.value = top_ranks[kc-1];
        res.complete = 1'b1;
      end else if (n > 0) begin
        res.value = top_ranks[n-1];
        res.complete = 1'b0;
      end else begin
        res.value = '0;
        res.complete = 1'b0;
      end
      expected_ranks.push_back(res);
      held_ranks = 0;
    end
  endtask

  // input side: accept and predict
  always @(posedge clk) begin
    beat_taken <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      rank_sample(sample_value, set_end);
      beats_accepted++;
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst && !(in_valid && !beat_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
        next_beat = samples_to_send.pop_front();
        in_valid <= 1'b1;
        sample_value <= next_beat.value;
        set_end <= next_beat.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_ranks.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result beat: value %0d complete %0b",
                   ranked_value, set_complete);
        mismatch_count++;
      end else begin
        want = expected_ranks.pop_front();
        if (ranked_value !== want.value || set_complete !== want.complete) begin
          if (mismatch_count < 10)
            $display("result %0d: expected value %0d complete %0b, got %0d complete %0b",
                     results_seen, want.value, want.complete, ranked_value, set_complete);
          mismatch_count++;
        end
      end
    end
  end

  task automatic push_sample(input logic signed [DATA_W-1:0] v, input logic last);
    sample_beat_t b;
    b.value = v;
    b.last = last;
    samples_to_send.push_back(b);
    items_queued++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return -1;
      endcase
    end
    if (r <= 3)
      return int'($urandom_range(0, 16)) - 8;
    return $urandom;
  endfunction

  task automatic push_set(input int len, input logic closed);
    for (int i = 0; i < len; i++)
      push_sample(pick_value(), closed && (i == len - 1));
  endtask

  task automatic settle();
    do @(negedge clk);
    while (beats_accepted != items_queued || expected_ranks.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input krs_reg_t idx, input logic [RANK_W-1:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == REG_RANK_K)
      cfg_rank = val;
    else
      cfg_largest = val[0];
    @(posedge clk);
  endtask

  initial begin
    int unsigned r;
    int phase_items;
    int len;
    logic open_set;
    logic [RANK_W-1:0] k_pick;
    open_set = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 3rd largest
    push_sample(32'sh7fff_ffff, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(5, 1'b1);
    push_sample(7, 1'b0);
    push_sample(7, 1'b0);
    push_sample(7, 1'b0);
    push_sample(7, 1'b1);
    push_sample(10, 1'b0);
    push_sample(20, 1'b1);
    push_sample(-5, 1'b1);
    settle();
    // rank zero acts as one; smallest first
    write_reg(REG_RANK_K, 5'd0);
    write_reg(REG_PICK_LARGEST, 5'd0);
    push_sample(3, 1'b0);
    push_sample(32'sh8000_0000, 1'b0);
    push_sample(32'sh7fff_ffff, 1'b1);
    settle();
    // rank beyond depth clamps; short set
    write_reg(REG_RANK_K, 5'd31);
    push_sample(9, 1'b0);
    push_sample(32'sh7fff_ffff, 1'b1);
    settle();
    // k shrinks inside an open set
    write_reg(REG_RANK_K, 5'd16);
    write_reg(REG_PICK_LARGEST, 5'd1);
    push_sample(1, 1'b0);
    push_sample(2, 1'b0);
    push_sample(3, 1'b0);
    settle();
    write_reg(REG_RANK_K, 5'd2);
    push_sample(0, 1'b1);
    settle();
    write_reg(REG_RANK_K, 5'd17);
    push_sample(6, 1'b0);
    push_sample(-6, 1'b1);
    push_sample(8, 1'b0);
    push_sample(9, 1'b0);
    settle();
    // order flips inside an open set
    write_reg(REG_PICK_LARGEST, 5'd0);
    push_sample(1, 1'b1);
    settle();

    while (items_queued < RANDOM_ITEMS + 26) begin
      r = $urandom_range(0, 9);
      case (r)
        0: k_pick = 5'd0;
        1: k_pick = 5'd31;
        2: k_pick = 5'd16;
        3: k_pick = 5'd17;
        4: k_pick = 5'd1;
        default: k_pick = RANK_W'($urandom_range(1, 16));
      endcase
      write_reg(REG_RANK_K, k_pick);
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_PICK_LARGEST, RANK_W'($urandom_range(0, 1)));
      idling = (items_queued < CALM_AFTER) && ($urandom_range(0, 4) != 0);
      @(posedge clk);
      phase_items = 0;
      while (phase_items < 120) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24);
        push_set(len, 1'b1);
        phase_items += len;
      end
      open_set = ($urandom_range(0, 2) == 0);
      if (open_set)
        push_set($urandom_range(1, 10), 1'b0);
      settle();
    end
    if (open_set) begin
      @(posedge clk);
      push_set(1, 1'b1);
    end
    settle();
    repeat (8) @(posedge clk);

    $display("%0d values in %0d sets went through; ranks 0 to 31, largest and smallest",
             beats_accepted, results_seen);
    $display("order, ties, short sets and settings changed inside open sets were covered");
    if (mismatch_count == 0 && expected_ranks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
